/* rtl/prq_pkg.sv */
// Shared types and constants for the priority ready-queue scheduler.
`default_nettype none
package prq_pkg;
    localparam logic [1:0] OP_READY   = 2'd0;
    localparam logic [1:0] OP_UNREADY = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_SCHED   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;

    localparam logic [7:0] SLICE_RESET = 8'd20;

    // Commands from controller to datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_RD_TASK,     // read link/level/slice/flag of request task
        CMD_READY,       // append request task
        CMD_UNR_SETUP,   // load walk pointer from level head
        CMD_UNR_HEAD,    // unlink task at head
        CMD_WALK_RD,     // read link of walk pointer
        CMD_WALK_STEP,   // examine link, unlink or advance
        CMD_TICK,
        CMD_SCHED_RD,    // read head link and slice
        CMD_SCHED,       // rotate spent head to tail
        CMD_SCHED_RLD    // reload new head slice
    } t_cmd;

    typedef struct packed {
        logic task_oor;    // task id outside range
        logic queued;      // flag of request task
        logic lvl_empty;   // recorded level empty
        logic is_head;     // request task is level head
        logic walk_end;    // walk link is empty marker
        logic walk_hit;    // walk link equals request task
        logic walk_limit;  // step counter exhausted
    } t_status;
endpackage
`default_nettype wire

/* rtl/priority_ready_queue_scheduler.sv */
// Top level: three-level ready-queue task scheduler.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  request | i_valid/o_ready, i_opcode, i_task_id,         | in
//          | i_priority_req                                |
//  result  | o_valid/i_ready, o_selected_task,             | out
//          | o_selected_valid, o_status                    |
//  config  | i_cfg_we, i_cfg_data (slice length)           | in
//
// One request at a time. Ready, tick and unready settled at decode pass through
// S_RD, S_DECIDE, S_FIX and S_DONE; unready at head adds S_UHEAD; sched adds S_SWAIT,
// and S_SRD and S_SRLD when the head slice is spent. An unready walk adds S_WALK_RD
// and S_WALK per link examined, set by the single read port of the link memory.
// Reset is synchronous, active low; link and level memories need no clear.
// The result sits in an output register; a new request enters once the
// controller is idle, even while that result waits for i_ready.
`default_nettype none
module priority_ready_queue_scheduler #(
    parameter int TASK_COUNT  = 32,
    parameter int LEVEL_COUNT = 3
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [1:0] i_opcode,
    input  wire  [4:0] i_task_id,
    input  wire  [1:0] i_priority_req,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [4:0] o_selected_task,
    output logic       o_selected_valid,
    output logic [1:0] o_status,
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_data
);
    import prq_pkg::*;

    logic [7:0] r_slice_len;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_slice_len <= SLICE_RESET;
        else if (i_cfg_we) r_slice_len <= i_cfg_data;
    end

    // hold request payload
    logic [4:0] r_task;
    logic [1:0] r_prio;
    logic       c_ready;
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_task   <= i_task_id;
            r_prio   <= i_priority_req;
        end
    end

    t_cmd    cmd;
    t_status stat;
    logic    done;
    logic [1:0] st;
    logic [4:0] sel;
    logic       selv;
    logic       head_zero;
    logic       out_free;

    // controller holds its result until the output slot frees
    assign o_ready  = c_ready;
    assign out_free = !o_valid || i_ready;

    prq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(c_ready),
        .i_opcode(i_opcode), .i_stat(stat), .i_head_zero(head_zero),
        .i_out_free(out_free), .o_cmd(cmd), .o_done(done), .o_status(st)
    );

    prq_datapath #(.TASK_COUNT(TASK_COUNT), .LEVEL_COUNT(LEVEL_COUNT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_task_id(r_task), .i_priority_req(r_prio), .i_slice_length(r_slice_len),
        .o_stat(stat), .o_head_zero(head_zero),
        .o_selected_task(sel), .o_selected_valid(selv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            if (done) begin
                o_valid          <= 1'b1;
                o_selected_task  <= sel;
                o_selected_valid <= selv;
                o_status         <= st;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/prq_datapath.sv */
// Datapath: queue pointers, per-task memories and the unlink walk.
`default_nettype none
module prq_datapath #(
    parameter int TASK_COUNT  = 32,
    parameter int LEVEL_COUNT = 3
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  prq_pkg::t_cmd     i_cmd,
    input  wire  [4:0]        i_task_id,
    input  wire  [1:0]        i_priority_req,
    input  wire  [7:0]        i_slice_length,
    output prq_pkg::t_status  o_stat,
    output logic              o_head_zero,
    output logic [4:0]        o_selected_task,
    output logic              o_selected_valid
);
    import prq_pkg::*;

    localparam int TW = $clog2(TASK_COUNT + 1);  // holds empty marker
    localparam int IW = $clog2(TASK_COUNT);
    localparam int LW = (LEVEL_COUNT > 2) ? $clog2(LEVEL_COUNT) : 1;
    localparam int CW = $clog2(TASK_COUNT + 1);
    localparam logic [TW-1:0] NO_TASK = TW'(TASK_COUNT);
    localparam int USER = 1;

    logic [TW-1:0] r_head [LEVEL_COUNT];
    logic [TW-1:0] r_tail [LEVEL_COUNT];
    logic          r_qflag [TASK_COUNT];
    logic          r_sl_wr [TASK_COUNT];   // slice written since reset

    // memories
    logic [TW-1:0] m_link  [TASK_COUNT];
    logic [LW-1:0] m_level [TASK_COUNT];
    logic [7:0]    m_slice [TASK_COUNT];

    logic [TW-1:0] r_link_q;     // registered link read
    logic [LW-1:0] r_level_q;
    logic [7:0]    r_slice_q;
    logic [TW-1:0] r_prev;       // walk pointer
    logic [LW-1:0] r_lvl;        // level in use
    logic [CW-1:0] r_cnt;

    // deferred link and slice updates
    logic          r_hit;
    logic [IW-1:0] r_hit_prev;
    logic          r_tick;
    logic          r_rot;
    logic [IW-1:0] r_rot_tl, r_rot_h;

    // request decode
    logic          task_oor;
    logic [IW-1:0] tidx;
    logic [TW-1:0] task_ext;
    logic [LW-1:0] req_lvl;
    assign task_oor = ({3'b0, i_task_id} >= 8'(TASK_COUNT)) && (TASK_COUNT < 32);
    assign tidx     = IW'(i_task_id);
    assign task_ext = TW'(i_task_id);
    always_comb begin
        if (int'(i_priority_req) >= LEVEL_COUNT) req_lvl = LW'(LEVEL_COUNT - 1);
        else req_lvl = LW'(i_priority_req);
    end

    logic [LW-1:0] rec_lvl;
    always_comb begin
        if (int'(r_level_q) >= LEVEL_COUNT) rec_lvl = LW'(LEVEL_COUNT - 1);
        else rec_lvl = r_level_q;
    end

    logic [IW-1:0] hidx, tlidx, pidx;
    assign hidx  = IW'(r_head[USER]);
    assign tlidx = IW'(r_tail[USER]);
    assign pidx  = IW'(r_prev);

    // ready: level already holds tasks, link old tail to new task
    logic          lvl_busy;
    logic [IW-1:0] rdy_tl;
    assign lvl_busy = (r_head[req_lvl] < NO_TASK) && (r_tail[req_lvl] < NO_TASK);
    assign rdy_tl   = IW'(r_tail[req_lvl]);

    logic slice_eff_zero;
    assign slice_eff_zero = (r_slice_q == 8'd0);
    assign o_head_zero    = (r_head[USER] < NO_TASK) && slice_eff_zero;

    always_comb begin
        o_stat.task_oor   = task_oor;
        o_stat.queued     = r_qflag[tidx];
        o_stat.lvl_empty  = (r_head[rec_lvl] >= NO_TASK);
        o_stat.is_head    = (r_head[rec_lvl] == task_ext);
        o_stat.walk_end   = (r_link_q >= NO_TASK);
        o_stat.walk_hit   = (r_link_q == task_ext);
        o_stat.walk_limit = (r_cnt == CW'(TASK_COUNT));
    end

    // Memory read address and slice write.
    logic          m_we_sl;
    logic [7:0]    m_wd_sl;
    logic [IW-1:0] m_ra;
    logic          m_rd;
    always_comb begin
        m_rd = 1'b0; m_ra = tidx;
        unique case (i_cmd)
            CMD_RD_TASK: begin
                m_rd = 1'b1; m_ra = tidx;
            end
            CMD_WALK_RD: begin
                m_rd = 1'b1; m_ra = pidx;
            end
            CMD_WALK_STEP: begin
                m_rd = 1'b1; m_ra = IW'(r_link_q);
            end
            CMD_TICK: begin
                m_rd = 1'b1; m_ra = hidx;
            end
            CMD_SCHED_RD: begin
                m_rd = 1'b1; m_ra = hidx;
            end
            default: ;
        endcase
    end
    // reload after sched, or tick decrement in the cycle after the slice read
    assign m_we_sl = (i_cmd == CMD_SCHED_RLD) || (r_tick && !slice_eff_zero);
    assign m_wd_sl = (i_cmd == CMD_SCHED_RLD) ? i_slice_length : r_slice_q - 8'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_READY) begin
            m_link[tidx]  <= NO_TASK;
            m_level[tidx] <= req_lvl;
            if (lvl_busy) m_link[rdy_tl] <= task_ext;
        end
        // walk hit: prev.link <= link(t), read during WALK_STEP
        if (r_hit) m_link[r_hit_prev] <= r_link_q;
        // sched rotation: old tail -> old head -> empty
        if (r_rot) begin
            m_link[r_rot_tl] <= TW'(r_rot_h);
            m_link[r_rot_h]  <= NO_TASK;
        end
        if (m_we_sl) m_slice[hidx] <= m_wd_sl;
        if (m_rd) begin
            r_link_q  <= m_link[m_ra];
            r_level_q <= m_level[m_ra];
            r_slice_q <= r_sl_wr[m_ra] ? m_slice[m_ra] : SLICE_RESET;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVEL_COUNT; l++) begin
                r_head[l] <= NO_TASK;
                r_tail[l] <= NO_TASK;
            end
            for (int k = 0; k < TASK_COUNT; k++) begin
                r_qflag[k] <= 1'b0;
                r_sl_wr[k] <= 1'b0;
            end
            r_hit <= 1'b0;
        end else begin
            r_hit <= 1'b0;
            if (m_we_sl) r_sl_wr[hidx] <= 1'b1;
            unique case (i_cmd)
                CMD_READY: begin
                    if (!lvl_busy) r_head[req_lvl] <= task_ext;
                    r_tail[req_lvl] <= task_ext;
                    r_qflag[tidx]   <= 1'b1;
                end
                CMD_UNR_SETUP: begin
                    r_lvl  <= rec_lvl;
                    r_prev <= r_head[rec_lvl];
                    r_cnt  <= '0;
                end
                CMD_UNR_HEAD: begin
                    if (r_link_q >= NO_TASK) begin
                        r_head[r_lvl] <= NO_TASK;
                        r_tail[r_lvl] <= NO_TASK;
                    end else begin
                        r_head[r_lvl] <= r_link_q;
                    end
                    r_qflag[tidx] <= 1'b0;
                end
                CMD_WALK_STEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (o_stat.walk_hit && !o_stat.walk_limit) begin
                        r_hit <= 1'b1;
                        r_hit_prev <= pidx;
                        if (r_tail[r_lvl] == task_ext) r_tail[r_lvl] <= r_prev;
                        r_qflag[tidx] <= 1'b0;
                    end else begin
                        r_prev <= r_link_q;
                    end
                end
                CMD_SCHED: begin
                    if (r_tail[USER] < NO_TASK && r_tail[USER] != r_head[USER]
                        && r_link_q < NO_TASK) begin
                        r_tail[USER] <= r_head[USER];
                        r_head[USER] <= r_link_q;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= 1'b0;
            r_rot  <= 1'b0;
        end else begin
            r_tick <= (i_cmd == CMD_TICK) && (r_head[USER] < NO_TASK);
            r_rot  <= (i_cmd == CMD_SCHED) && r_tail[USER] < NO_TASK
                      && r_tail[USER] != r_head[USER] && r_link_q < NO_TASK;
            r_rot_tl <= tlidx;
            r_rot_h  <= hidx;
        end
    end

    // selection
    always_comb begin
        o_selected_task  = 5'd0;
        o_selected_valid = 1'b0;
        for (int l = LEVEL_COUNT - 1; l >= 0; l--) begin
            if (r_head[l] < NO_TASK) begin
                o_selected_task  = 5'(r_head[l]);
                o_selected_valid = 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/prq_ctrl.sv */
// Controller state machine sequencing each request.
`default_nettype none
module prq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [1:0]        i_opcode,
    input  prq_pkg::t_status  i_stat,
    input  wire               i_head_zero,
    input  wire               i_out_free,
    output prq_pkg::t_cmd     o_cmd,
    output logic              o_done,
    output logic [1:0]        o_status
);
    import prq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_DECIDE, S_UHEAD, S_WALK_RD, S_WALK, S_SRD, S_SWAIT,
        S_SRLD, S_FIX, S_DONE
    } t_state;

    t_state r_state;
    logic [1:0] r_op;

    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_done  = (r_state == S_DONE) && i_out_free;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE:    o_cmd = CMD_NONE;
            S_RD:      o_cmd = CMD_RD_TASK;
            S_DECIDE: begin
                if (r_op == OP_READY && !i_stat.task_oor && !i_stat.queued)
                    o_cmd = CMD_READY;
                else if (r_op == OP_UNREADY) o_cmd = CMD_UNR_SETUP;
                else if (r_op == OP_TICK) o_cmd = CMD_TICK;
                else if (r_op == OP_SCHED) o_cmd = CMD_SCHED_RD;
            end
            S_UHEAD:   o_cmd = CMD_UNR_HEAD;
            S_WALK_RD: o_cmd = CMD_WALK_RD;
            S_WALK:    o_cmd = CMD_WALK_STEP;
            S_SRD:     o_cmd = CMD_SCHED;
            S_SRLD:    o_cmd = CMD_SCHED_RLD;
            default:   o_cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_status <= ST_OK;
            r_op     <= OP_READY;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op <= i_opcode; r_state <= S_RD; o_status <= ST_OK;
                end
                S_RD: r_state <= S_DECIDE;
                S_DECIDE: begin
                    unique case (r_op)
                        OP_READY: begin
                            if (!i_stat.task_oor && i_stat.queued) o_status <= ST_DUPLICATE;
                            r_state <= S_FIX;
                        end
                        OP_UNREADY: begin
                            if (i_stat.task_oor) begin
                                o_status <= ST_NOT_FOUND; r_state <= S_FIX;
                            end else if (i_stat.lvl_empty) r_state <= S_FIX;
                            else if (!i_stat.queued) begin
                                o_status <= ST_NOT_FOUND; r_state <= S_FIX;
                            end else if (i_stat.is_head) r_state <= S_UHEAD;
                            else r_state <= S_WALK_RD;
                        end
                        OP_TICK:  r_state <= S_FIX;
                        default:  r_state <= S_SWAIT;
                    endcase
                end
                S_UHEAD:   r_state <= S_FIX;
                S_WALK_RD: r_state <= S_WALK;
                S_WALK: begin
                    if (i_stat.walk_end || i_stat.walk_limit) begin
                        o_status <= ST_NOT_FOUND; r_state <= S_FIX;
                    end else if (i_stat.walk_hit) r_state <= S_FIX;
                    else r_state <= S_WALK_RD;
                end
                S_SWAIT: r_state <= i_head_zero ? S_SRD : S_FIX;
                S_SRD:   r_state <= S_SRLD;
                S_SRLD:  r_state <= S_FIX;
                S_FIX:   r_state <= S_DONE;
                S_DONE:  if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* tb/tb_priority_ready_queue_scheduler.sv */
// Testbench for the three-level ready-queue scheduler: directed and random requests, checked against a predictor.
`timescale 1ns / 1ps
module tb_priority_ready_queue_scheduler;
    import prq_pkg::*;

    localparam int NTASK     = 32;
    localparam int NLEVEL    = 3;
    localparam int USER_LVL  = 1;
    localparam logic [5:0] NO_TASK = 6'd32;
    localparam int WDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 100;  // covers the walk of a full list
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] tid;
        logic [1:0] prio;
    } req_t;

    typedef struct packed {
        logic [4:0] sel_task;
        logic       sel_valid;
        logic [1:0] status;
    } sel_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_opcode = '0;
    logic [4:0] i_task_id = '0;
    logic [1:0] i_priority_req = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [4:0] o_selected_task;
    logic       o_selected_valid;
    logic [1:0] o_status;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = '0;

    priority_ready_queue_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_task_id       (i_task_id),
        .i_priority_req  (i_priority_req),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_selected_task (o_selected_task),
        .o_selected_valid(o_selected_valid),
        .o_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Scheduler state mirror
    logic [7:0] slice_cfg = SLICE_RESET;
    logic [5:0] head_q [NLEVEL];
    logic [5:0] tail_q [NLEVEL];
    logic [5:0] link_q [NTASK];
    logic [1:0] lvl_of [NTASK];
    logic [7:0] slice_of [NTASK];
    logic       on_queue [NTASK];

    req_t pending_q [$];   // requests still to be driven
    sel_t select_q [$];    // predicted selections awaiting the result channel
    bit   readied [NTASK]; // ever readied at generation time; unready only targets these

    int   n_fail = 0;
    int   n_req = 0;
    int   n_res = 0;
    int   op_seen [4];
    int   st_seen [3];
    bit   quiet = 1'b0;    // no idling on either side
    bit   drv_busy = 1'b0;
    int   idle_cycles = 0;

    function automatic logic [1:0] enqueue_task(logic [4:0] t, logic [1:0] p);
        logic [1:0] l;
        if (on_queue[t]) return ST_DUPLICATE;
        l = (p >= NLEVEL) ? 2'(NLEVEL - 1) : p;
        if (head_q[l] == NO_TASK || tail_q[l] == NO_TASK) head_q[l] = {1'b0, t};
        else link_q[tail_q[l][4:0]] = {1'b0, t};
        link_q[t] = NO_TASK;
        tail_q[l] = {1'b0, t};
        lvl_of[t] = l;
        on_queue[t] = 1'b1;
        return ST_OK;
    endfunction

    function automatic logic [1:0] dequeue_task(logic [4:0] t);
        logic [1:0] l;
        logic [5:0] prev, cur;
        l = lvl_of[t];
        prev = head_q[l];
        if (prev == NO_TASK) return ST_OK;
        if (!on_queue[t]) return ST_NOT_FOUND;
        if (prev == {1'b0, t}) begin
            head_q[l] = link_q[t];
            if (head_q[l] == NO_TASK) tail_q[l] = NO_TASK;
            on_queue[t] = 1'b0;
            return ST_OK;
        end
        for (int n = 0; n < NTASK; n++) begin
            cur = link_q[prev[4:0]];
            if (cur == NO_TASK) return ST_NOT_FOUND;
            if (cur == {1'b0, t}) begin
                link_q[prev[4:0]] = link_q[t];
                if (tail_q[l] == {1'b0, t}) tail_q[l] = prev;
                on_queue[t] = 1'b0;
                return ST_OK;
            end
            prev = cur;
        end
        return ST_NOT_FOUND;
    endfunction

    // Rotate the spent user head to the tail, then reload the new head's slice.
    function automatic void rotate_user();
        logic [5:0] h, tl, nh;
        h = head_q[USER_LVL];
        tl = tail_q[USER_LVL];
        if (h == NO_TASK || slice_of[h[4:0]] != 0) return;
        if (tl != NO_TASK && tl != h) begin
            nh = link_q[h[4:0]];
            if (nh != NO_TASK) begin
                link_q[tl[4:0]] = h;
                tail_q[USER_LVL] = h;
                link_q[h[4:0]] = NO_TASK;
                head_q[USER_LVL] = nh;
                h = nh;
            end
        end
        slice_of[h[4:0]] = slice_cfg;
    endfunction

    function automatic sel_t schedule_req(req_t r);
        sel_t s;
        logic [5:0] h;
        s = '0;
        case (r.opcode)
            OP_READY:   s.status = enqueue_task(r.tid, r.prio);
            OP_UNREADY: s.status = dequeue_task(r.tid);
            OP_TICK: begin
                h = head_q[USER_LVL];
                if (h != NO_TASK && slice_of[h[4:0]] != 0)
                    slice_of[h[4:0]] = slice_of[h[4:0]] - 8'd1;
            end
            default:    rotate_user();
        endcase
        for (int i = NLEVEL - 1; i >= 0; i--) begin
            if (head_q[i] != NO_TASK) begin
                s.sel_task = head_q[i][4:0];
                s.sel_valid = 1'b1;
            end
        end
        return s;
    endfunction

    // Driver: request channel, predicts on each accepted request
    int   gap_left = 0;
    req_t cur_req = '0;
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            select_q.push_back(schedule_req(cur_req));
            op_seen[cur_req.opcode]++;
            n_req++;
            drv_busy = 1'b0;
        end
        if (i_rst_n && !drv_busy) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                gap_left = $urandom_range(0, 2);
            end else if (pending_q.size() > 0) begin
                cur_req = pending_q.pop_front();
                drv_busy = 1'b1;
            end
        end
        i_valid <= drv_busy;
        i_opcode <= cur_req.opcode;
        i_task_id <= cur_req.tid;
        i_priority_req <= cur_req.prio;
    end

    // Monitor: result channel, random stalls plus one long hold-off
    int  stall_left = 0;
    int  hold_left = 0;
    bit  held = 1'b0;
    sel_t want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            n_res++;
            if (select_q.size() == 0) begin
                $error("result with nothing expected: task %0d", o_selected_task);
                n_fail++;
            end else begin
                want = select_q.pop_front();
                st_seen[want.status]++;
                if (o_selected_task !== want.sel_task) begin
                    $error("selected_task exp %0d got %0d", want.sel_task, o_selected_task);
                    n_fail++;
                end
                if (o_selected_valid !== want.sel_valid) begin
                    $error("selected_valid exp %0d got %0d", want.sel_valid, o_selected_valid);
                    n_fail++;
                end
                if (o_status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_status);
                    n_fail++;
                end
            end
        end
        // long hold-off once the run is underway: block fills and stalls requests
        if (!held && n_res == 300) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog: cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("timeout: %0d requests, %0d results", n_req, n_res);
            $display("[priority_ready_queue_scheduler] ERROR");
            $finish;
        end
    end

    task automatic add_req(logic [1:0] op, logic [4:0] t, logic [1:0] p);
        req_t r;
        r.opcode = op;
        r.tid = t;
        r.prio = p;
        if (op == OP_READY) readied[t] = 1'b1;
        pending_q.push_back(r);
    endtask

    // Sender pause: everything driven and every result back, then drain time.
    task automatic wait_drained();
        while (pending_q.size() != 0 || drv_busy || select_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slice(logic [7:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        slice_cfg = v;
    endtask

    task automatic add_random(int n);
        int k, pick;
        logic [4:0] t;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            // small task pool most of the time so lists get long and repeats happen
            t = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 9));
            if (k < 30) begin
                add_req(OP_READY, t, 2'($urandom_range(0, 3)));
            end else if (k < 55) begin
                pick = 0;
                while (pick < 50 && !readied[t]) begin
                    t = 5'($urandom);
                    pick++;
                end
                if (readied[t]) add_req(OP_UNREADY, t, 2'($urandom));
                else add_req(OP_TICK, t, 2'($urandom));
            end else if (k < 85) begin
                add_req(OP_TICK, 5'($urandom), 2'($urandom));
            end else begin
                add_req(OP_SCHED, 5'($urandom), 2'($urandom));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NLEVEL; i++) begin
            head_q[i] = NO_TASK;
            tail_q[i] = NO_TASK;
        end
        for (int i = 0; i < NTASK; i++) begin
            link_q[i] = NO_TASK;
            lvl_of[i] = '0;
            slice_of[i] = SLICE_RESET;
            on_queue[i] = 1'b0;
            readied[i] = 1'b0;
        end
        for (int i = 0; i < 4; i++) op_seen[i] = 0;
        for (int i = 0; i < 3; i++) st_seen[i] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty queues, extremes, saturation, duplicate, unlink cases
        add_req(OP_SCHED, 5'd0, 2'd0);        // nothing queued
        add_req(OP_TICK, 5'd31, 2'd3);
        add_req(OP_READY, 5'd0, 2'd2);
        add_req(OP_READY, 5'd31, 2'd1);
        add_req(OP_READY, 5'd5, 2'd3);        // level saturates to idle
        add_req(OP_READY, 5'd31, 2'd0);       // duplicate
        add_req(OP_READY, 5'd1, 2'd0);
        add_req(OP_UNREADY, 5'd1, 2'd0);      // unlink at head, level empties
        add_req(OP_UNREADY, 5'd1, 2'd0);      // not queued, level empty
        add_req(OP_UNREADY, 5'd5, 2'd0);      // walk hits tail
        add_req(OP_UNREADY, 5'd5, 2'd0);      // not queued, level non-empty
        add_req(OP_READY, 5'd2, 2'd1);
        add_req(OP_SCHED, 5'd0, 2'd0);        // slice not spent
        add_req(OP_UNREADY, 5'd31, 2'd0);
        add_req(OP_TICK, 5'd0, 2'd0);
        add_req(OP_UNREADY, 5'd2, 2'd0);
        add_req(OP_UNREADY, 5'd0, 2'd0);      // all empty again
        add_random(180);

        write_slice(8'd0);                    // zero reload: a reloaded head is spent at once
        add_req(OP_READY, 5'd3, 2'd1);
        add_req(OP_READY, 5'd4, 2'd1);
        add_random(200);

        write_slice(8'd1);
        add_random(200);
        write_slice(8'd255);
        add_random(150);
        write_slice(8'd3);
        wait_drained();
        quiet = 1'b1;                         // final stretch without idling
        add_random(250);

        wait_drained();
        $display("covered %0d requests (ready %0d, unready %0d, tick %0d, sched %0d)",
                 n_req, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("statuses ok %0d, not found %0d, duplicate %0d; slice lengths 20/0/1/255/3",
                 st_seen[0], st_seen[1], st_seen[2]);
        if (n_fail == 0) begin
            $display("[priority_ready_queue_scheduler] OK");
        end else begin
            $display("[priority_ready_queue_scheduler] ERROR");
        end
        $finish;
    end
endmodule
